@@ design/vtp_pkg.sv @@
// Shared types, codes and helpers for the vertex transform pipeline.
// No dependencies; used by vtp_mac, vtp_div_step and the top level.
package vtp_pkg;

  // operation selector codes
  localparam logic [1:0] FUNC_COORD  = 2'd0;
  localparam logic [1:0] FUNC_NORMAL = 2'd1;
  localparam logic [1:0] FUNC_HOMOG  = 2'd2;

  // 1e-5 in raw Q32.32
  localparam logic signed [63:0] EPS_Q3232 = 64'sd42950;

  // quotient bits: 16 integer bits plus 17 fraction bits (one for rounding)
  localparam int DIV_STEPS = 33;

  localparam int NUM_REGS = 8;

  typedef logic [NUM_REGS-1:0][63:0] matrix_t;

  // column sums leaving the multiply-accumulate section
  typedef struct packed {
    logic [1:0]        func;
    logic [3:0][63:0]  acc;
    logic [3:0]        csat;
  } acc_beat_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] num;
    logic [32:0] quo;
    logic        neg;
    logic        ovf;
  } div_lane_t;

  // everything that travels down the divider chain
  typedef struct packed {
    div_lane_t [2:0]   lane;
    logic [63:0]       den;
    logic [1:0]        func;
    logic              degen;
    logic              sat;
    logic [3:0][31:0]  res;
  } div_beat_t;

  // signed Q16.16 matrix entry of row r, column c
  function automatic logic signed [31:0] entry(input matrix_t m, input int r, input int c);
    logic [63:0] word;
    word = m[r*2 + c/2];
    return (c % 2 == 1) ? $signed(word[63:32]) : $signed(word[31:0]);
  endfunction

endpackage

@@ design/vtp_mac.sv @@
// Multiply-accumulate section: input register, 12 products, clamped column sums.
// Depends on vtp_pkg.
module vtp_mac (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [1:0]          func,
  input  logic [95:0]         point,
  input  vtp_pkg::matrix_t    matrix,
  output logic                out_valid,
  output vtp_pkg::acc_beat_t  out_beat
);

  logic              a_valid;
  logic [1:0]        a_func;
  logic [2:0][31:0]  a_v;

  logic                   b_valid;
  logic [1:0]             b_func;
  logic [3:0][2:0][63:0]  b_prod;
  logic [3:0][47:0]       b_trans;

  logic [3:0][65:0] sum;

  // stage a: input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_func <= func;
      a_v    <= point;
    end
  end

  // stage b: one 32x32 product per entry of the first three rows, translation row scaled to Q32.32 (zero for normals)
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_func <= a_func;
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          b_prod[c][r] <= $signed(a_v[r]) * vtp_pkg::entry(matrix, r, c);
        end
        if (a_func == vtp_pkg::FUNC_NORMAL) begin
          b_trans[c] <= '0;
        end else begin
          b_trans[c] <= {vtp_pkg::entry(matrix, 3, c), 16'h0000};
        end
      end
    end
  end

  // stage c: exact column sums clamped to the 64-bit accumulator
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c] = 66'($signed(b_prod[c][0])) + 66'($signed(b_prod[c][1]))
             + 66'($signed(b_prod[c][2])) + 66'($signed(b_trans[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_beat.func <= b_func;
      for (int c = 0; c < 4; c++) begin
        if ($signed(sum[c]) > $signed(66'sh0_7FFF_FFFF_FFFF_FFFF)) begin
          out_beat.acc[c]  <= 64'h7FFF_FFFF_FFFF_FFFF;
          out_beat.csat[c] <= 1'b1;
        end else if ($signed(sum[c]) < -$signed(66'sh0_8000_0000_0000_0000)) begin
          out_beat.acc[c]  <= 64'h8000_0000_0000_0000;
          out_beat.csat[c] <= 1'b1;
        end else begin
          out_beat.acc[c]  <= sum[c][63:0];
          out_beat.csat[c] <= 1'b0;
        end
      end
    end
  end

endmodule

@@ design/vtp_div_step.sv @@
// One registered step of the restoring divider, all three lanes at once.
// Depends on vtp_pkg.
module vtp_div_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  vtp_pkg::div_beat_t  in_beat,
  output logic                out_valid,
  output vtp_pkg::div_beat_t  out_beat
);

  vtp_pkg::div_beat_t beat_next;
  logic [64:0] shifted;
  logic [64:0] trial;

  // shift in the next numerator bit, subtract when it fits
  always_comb begin
    beat_next = in_beat;
    shifted   = '0;
    trial     = '0;
    for (int l = 0; l < 3; l++) begin
      shifted = {in_beat.lane[l].rem, in_beat.lane[l].num[15]};
      trial   = shifted - {1'b0, in_beat.den};
      if (!trial[64]) begin
        beat_next.lane[l].rem = trial[63:0];
        beat_next.lane[l].quo = {in_beat.lane[l].quo[31:0], 1'b1};
      end else begin
        beat_next.lane[l].rem = shifted[63:0];
        beat_next.lane[l].quo = {in_beat.lane[l].quo[31:0], 1'b0};
      end
      beat_next.lane[l].num = {in_beat.lane[l].num[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_beat <= beat_next;
    end
  end

endmodule

@@ design/vertex_transform_perspective.sv @@
// Top level of the vertex transform: config registers, rounding, divider chain, output.
// Depends on vtp_pkg, vtp_mac and vtp_div_step.
//
// Usage:
//   Each input beat carries a point (s_tdata: in_x, in_y, in_z) and an operation
//   in s_tuser. The point is multiplied as [x y z 1], or as [x y z 0] for normals,
//   by the 4x4 matrix held in eight 64-bit registers written over the cfg channel
//   (cfg_index 0..7, other indexes are dropped; cfg_ready is always high). Write
//   the matrix only while no beat is in flight.
//   Each point yields one result beat: m_tdata holds out_x, out_y, out_z, out_w,
//   m_tuser holds degenerate and saturated.
//   Beats pass three registers for input, products and column sums, one for
//   rounding and divider setup, 33 for the one-bit-per-stage quotient of the
//   perspective divide, one for the output register.
//   Throughput is one beat per cycle: the pipeline moves whenever the output
//   register is empty or being taken.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits and loads the identity matrix.
module vertex_transform_perspective (
  input  logic          clk,
  input  logic          rst,
  // config write channel
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [3:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  // input stream
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [95:0]   s_tdata,   // in_x, in_y, in_z
  input  logic [1:0]    s_tuser,   // func
  // output stream
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [127:0]  m_tdata,   // out_x, out_y, out_z, out_w
  output logic [1:0]    m_tuser    // degenerate, saturated
);

  localparam int NSTEP = vtp_pkg::DIV_STEPS;

  vtp_pkg::matrix_t   matrix;
  logic               en;

  logic               c_valid;
  vtp_pkg::acc_beat_t c_beat;

  logic                              d_valid;
  vtp_pkg::div_beat_t                d_beat_next;
  logic [NSTEP:0]                    chain_valid;
  vtp_pkg::div_beat_t [NSTEP:0]      chain_beat;

  logic [63:0]        w_mag;
  logic [79:0]        ovf_lim;
  logic [63:0]        num_mag;
  logic [48:0]        rnd;
  logic               any_sat;

  vtp_pkg::div_beat_t f_beat;
  logic [3:0][31:0]   out_res;
  logic               out_sat;
  logic [33:0]        rq;
  logic [32:0]        mag;
  logic [32:0]        limit;
  logic [31:0]        mag32;

  // pipeline advances when the output register is free
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // matrix registers, identity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix <= {64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
                 64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
                 64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
                 64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000};
    end else if (cfg_valid && cfg_ready && !cfg_index[3]) begin
      matrix[cfg_index[2:0]] <= cfg_data;
    end
  end

  vtp_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .func      (s_tuser),
    .point     (s_tdata),
    .matrix    (matrix),
    .out_valid (c_valid),
    .out_beat  (c_beat)
  );

  // stage d: Q16.16 rounding for the plain operations, divider setup for the divide
  always_comb begin
    d_beat_next      = '0;
    d_beat_next.func = c_beat.func;
    w_mag   = c_beat.acc[3][63] ? 64'(-c_beat.acc[3]) : c_beat.acc[3];
    ovf_lim = {1'b0, w_mag, 15'h0000} + 80'(w_mag);
    num_mag = '0;
    rnd     = '0;
    any_sat = 1'b0;
    d_beat_next.den = w_mag;
    case (c_beat.func)
      vtp_pkg::FUNC_COORD: begin
        if ($signed(c_beat.acc[3]) > -vtp_pkg::EPS_Q3232
            && $signed(c_beat.acc[3]) < vtp_pkg::EPS_Q3232) begin
          d_beat_next.degen = 1'b1;
        end else begin
          d_beat_next.sat = |c_beat.csat;
        end
        for (int l = 0; l < 3; l++) begin
          num_mag = c_beat.acc[l][63] ? 64'(-c_beat.acc[l]) : c_beat.acc[l];
          d_beat_next.lane[l].neg = c_beat.acc[l][63] ^ c_beat.acc[3][63];
          d_beat_next.lane[l].ovf = {16'h0000, num_mag} >= ovf_lim;
          d_beat_next.lane[l].rem = {16'h0000, num_mag[63:16]};
          d_beat_next.lane[l].num = num_mag;
        end
      end
      vtp_pkg::FUNC_NORMAL, vtp_pkg::FUNC_HOMOG: begin
        for (int c = 0; c < 4; c++) begin
          if (c < 3 || c_beat.func == vtp_pkg::FUNC_HOMOG) begin
            any_sat = any_sat | c_beat.csat[c];
            rnd = 49'($signed(c_beat.acc[c][63:16])) + 49'(c_beat.acc[c][15]);
            if ($signed(rnd) > $signed(49'sh0_7FFF_FFFF)) begin
              d_beat_next.res[c] = 32'h7FFF_FFFF;
              any_sat = 1'b1;
            end else if ($signed(rnd) < -$signed(49'sh0_8000_0000)) begin
              d_beat_next.res[c] = 32'h8000_0000;
              any_sat = 1'b1;
            end else begin
              d_beat_next.res[c] = rnd[31:0];
            end
          end
        end
        d_beat_next.sat = any_sat;
      end
      default: begin
        d_beat_next.func = c_beat.func;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain_beat[0] <= d_beat_next;
    end
  end

  assign chain_valid[0] = d_valid;

  // divider chain, one quotient bit per stage
  for (genvar s = 0; s < NSTEP; s++) begin : g_div
    vtp_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[s]),
      .in_beat   (chain_beat[s]),
      .out_valid (chain_valid[s+1]),
      .out_beat  (chain_beat[s+1])
    );
  end

  // final rounding and clamping of the quotients
  assign f_beat = chain_beat[NSTEP];

  always_comb begin
    out_res = '0;
    out_sat = f_beat.sat;
    rq      = '0;
    mag     = '0;
    limit   = '0;
    mag32   = '0;
    if (f_beat.func == vtp_pkg::FUNC_COORD) begin
      if (f_beat.degen) begin
        out_sat = 1'b0;
      end else begin
        for (int l = 0; l < 3; l++) begin
          limit = f_beat.lane[l].neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
          rq    = {1'b0, f_beat.lane[l].quo} + 34'd1;
          mag   = rq[33:1];
          if (f_beat.lane[l].ovf || mag > limit) begin
            mag     = limit;
            out_sat = 1'b1;
          end
          mag32 = mag[31:0];
          out_res[l] = f_beat.lane[l].neg ? 32'(-mag32) : mag32;
        end
      end
    end else begin
      out_res = f_beat.res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= chain_valid[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= out_res;
      m_tuser <= {out_sat, f_beat.degen};
    end
  end

  // a degenerate point reports no saturation
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("degenerate and saturated both set");

  // a degenerate point returns all zeros
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("degenerate result not zero");

  // a waiting result holds back new input
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

endmodule
